// ===== hdl/serial_speech_rom_emulator_macros.svh =====
// Assertion macros shared by the serial speech ROM emulator modules.
// Every module that asserts includes this header; the including scope must
// provide clk and rst.
`ifndef SERIAL_SPEECH_ROM_EMULATOR_MACROS_SVH
`define SERIAL_SPEECH_ROM_EMULATOR_MACROS_SVH

`ifndef ASSERT_OFF

// Checked at every rising edge of clk outside of reset.
`define SSRE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge of clk, reset included.
`define SSRE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SSRE_ASSERT(lbl, prop, msg)
`define SSRE_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== hdl/ssre_pkg.sv =====
// Package for the serial speech ROM emulator: sizes, word types and commands.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package ssre_pkg;

  // Address geometry.
  localparam int ADDRESS_BITS     = 20;
  localparam int SLOT_OFFSET_BITS = 14;
  localparam int ADDRESS_NIBBLES  = 5;
  localparam int NIBBLE_COUNT_W   = 3;
  localparam int SLOT_W           = 4;
  localparam int SLOTS            = 1 << SLOT_W;
  localparam int NEXT_ADDR_W      = 20;
  localparam int BIT_POS_W        = 4;
  localparam int BYTE_BITS        = 8;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

  // Bus operation codes as they arrive on the op field.
  localparam logic OP_ADDRESS = 1'b0;
  localparam logic OP_READ    = 1'b1;

  // Command kinds after classification.
  typedef enum logic {
    CMD_ADDRESS = 1'b0,
    CMD_READ    = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    logic       op;
    logic [3:0] nibble;
    logic       sensed_line;
    logic [7:0] rom_byte;
  } item_t;

  typedef struct packed {
    logic                   drive_enable;
    logic                   data_bit;
    logic [NEXT_ADDR_W-1:0] next_byte_address;
    logic                   conflict;
    logic [1:0]             phase;
  } result_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [3:0] nibble;
    logic       sensed_line;
    logic [7:0] rom_byte;
  } cmd_t;

endpackage

// ===== hdl/ssre_front.sv =====
// Front end of the serial speech ROM emulator: accepts bus event words and
// classifies them into commands for the queue. Depends on ssre_pkg.
`timescale 1ns / 1ps

module ssre_front (
  input  logic            item_valid,
  output logic            item_stall,
  input  ssre_pkg::item_t item,
  input  logic            q_full,
  output logic            push,
  output ssre_pkg::cmd_t  cmd
);
  import ssre_pkg::*;

  // The queue sets the pace of the input channel.
  assign item_stall = q_full;
  assign push       = item_valid && !q_full;

  // Classify the bus event and carry its nibble, sensed line and ROM byte along.
  always_comb begin
    cmd.nibble      = item.nibble;
    cmd.sensed_line = item.sensed_line;
    cmd.rom_byte    = item.rom_byte;
    unique case (item.op)
      OP_ADDRESS: cmd.kind = CMD_ADDRESS;
      OP_READ:    cmd.kind = CMD_READ;
      default:    cmd.kind = CMD_READ;
    endcase
  end

endmodule

// ===== hdl/ssre_queue.sv =====
// Short command queue between front and back of the serial speech ROM
// emulator, so that each side can stall on its own. Depends on ssre_pkg.
`timescale 1ns / 1ps

module ssre_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ssre_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           q_valid,
  output ssre_pkg::cmd_t head
);
  import ssre_pkg::*;
  `include "serial_speech_rom_emulator_macros.svh"

  cmd_t                entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCOUNT_W-1:0] count;

  assign full    = (count == QCOUNT_W'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign head    = entries[rd_ptr];

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `SSRE_ASSERT(a_no_overflow, push |-> !full, "queue written while full")
  `SSRE_ASSERT(a_no_underflow, pop |-> q_valid, "queue read while empty")
  `SSRE_ASSERT(a_count_step, (push && !pop) |=> count == $past(count) + 1'b1,
               "queue count did not follow a lone push")

endmodule

// ===== hdl/ssre_back.sv =====
// Back end of the serial speech ROM emulator: address loading, bit-serial
// read-out, line conflict detection and the per-slot ignore marks, with the
// registered result word. Depends on ssre_pkg.
`timescale 1ns / 1ps

module ssre_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  ssre_pkg::cmd_t    head,
  output logic              pop,
  output logic              result_valid,
  input  logic              result_stall,
  output ssre_pkg::result_t result
);
  import ssre_pkg::*;
  `include "serial_speech_rom_emulator_macros.svh"

  typedef enum logic [1:0] {
    ST_LOAD  = 2'd0,
    ST_DUMMY = 2'd1,
    ST_FIRST = 2'd2,
    ST_READ  = 2'd3
  } state_t;

  state_t                    state, state_next;
  logic [NIBBLE_COUNT_W-1:0] nib_count, nib_count_next;
  logic [ADDRESS_BITS-1:0]   addr, addr_next;
  logic [BIT_POS_W-1:0]      bit_pos, bit_pos_next;
  logic [BYTE_BITS-1:0]      shift_byte, shift_byte_next;
  logic                      last_bit, last_bit_next;
  logic                      emulating, emulating_next;
  logic [SLOTS-1:0]          ignored, ignored_next;
  result_t                   result_next;

  logic                      fire;
  logic [ADDRESS_BITS-1:0]   addr_inc;
  logic [ADDRESS_BITS-1:0]   addr_loaded;
  logic [NIBBLE_COUNT_W:0]   count_inc;
  logic [SLOT_W-1:0]         cur_slot;
  logic [SLOT_W-1:0]         look_slot;
  logic [ADDRESS_BITS-1:0]   look_addr;
  logic                      look_ignored;
  logic                      mark;
  logic [BIT_POS_W-1:0]      bit_eff;
  logic [BYTE_BITS-1:0]      byte_eff;
  logic [2:0]                bit_sel;

  // A word moves on whenever the result register is free or being taken.
  assign fire = q_valid && (!result_valid || !result_stall);
  assign pop  = fire;

  assign addr_inc    = addr + 1'b1;
  assign count_inc   = {1'b0, nib_count} + 1'b1;
  assign addr_loaded = addr | (ADDRESS_BITS'(head.nibble) << {nib_count, 2'b00});
  assign cur_slot    = SLOT_W'(addr >> SLOT_OFFSET_BITS);

  // A read strobe while driving finds the line at a level other than the driven bit.
  assign mark = (head.kind == CMD_READ) && (state == ST_READ) && emulating &&
                (head.sensed_line != last_bit);

  // One ignore-mark lookup: the freshly loaded address or the next byte.
  assign look_addr    = (head.kind == CMD_ADDRESS) ? addr_loaded : addr_inc;
  assign look_slot    = SLOT_W'(look_addr >> SLOT_OFFSET_BITS);
  assign look_ignored = ignored[look_slot] || (mark && (look_slot == cur_slot));

  // Next state for the command at the queue head.
  always_comb begin
    state_next      = state;
    nib_count_next  = nib_count;
    addr_next       = addr;
    bit_pos_next    = bit_pos;
    shift_byte_next = shift_byte;
    last_bit_next   = last_bit;
    emulating_next  = emulating;
    ignored_next    = ignored;
    bit_eff         = bit_pos;
    byte_eff        = shift_byte;
    bit_sel         = 3'd7 - bit_pos[2:0];

    unique case (head.kind)
      CMD_ADDRESS: begin
        if (state == ST_LOAD) begin
          addr_next      = addr_loaded;
          nib_count_next = count_inc[NIBBLE_COUNT_W-1:0];
          if (count_inc >= (NIBBLE_COUNT_W + 1)'(ADDRESS_NIBBLES)) begin
            nib_count_next = '0;
            state_next     = ST_DUMMY;
            emulating_next = !look_ignored;
          end
        end else begin
          // Any other phase: the nibble opens a new address load.
          addr_next      = ADDRESS_BITS'(head.nibble);
          nib_count_next = NIBBLE_COUNT_W'(1);
          state_next     = ST_LOAD;
          emulating_next = 1'b0;
          bit_pos_next   = '0;
        end
      end
      CMD_READ: begin
        unique case (state)
          ST_LOAD: begin
            addr_next      = '0;
            nib_count_next = '0;
            emulating_next = 1'b0;
            bit_pos_next   = '0;
          end
          ST_DUMMY: begin
            state_next = ST_FIRST;
          end
          ST_FIRST: begin
            byte_eff        = head.rom_byte;
            bit_eff         = '0;
            shift_byte_next = head.rom_byte;
            state_next      = ST_READ;
            bit_sel         = 3'd7;
            last_bit_next   = head.rom_byte[3'd7];
            bit_pos_next    = BIT_POS_W'(1);
          end
          ST_READ: begin
            // Check the previously driven bit against the line.
            if (mark) begin
              ignored_next[cur_slot] = 1'b1;
              emulating_next         = 1'b0;
            end
            if (bit_pos >= BIT_POS_W'(BYTE_BITS)) begin
              addr_next       = addr_inc;
              byte_eff        = head.rom_byte;
              bit_eff         = '0;
              shift_byte_next = head.rom_byte;
              if (addr_inc[SLOT_OFFSET_BITS-1:0] == '0) begin
                emulating_next = !look_ignored;
              end
            end
            bit_sel       = 3'd7 - bit_eff[2:0];
            last_bit_next = byte_eff[bit_sel];
            bit_pos_next  = bit_eff + 1'b1;
          end
          default: begin
            state_next = ST_LOAD;
          end
        endcase
      end
      default: begin
        state_next = state;
      end
    endcase
  end

  // Result word for this command.
  always_comb begin
    result_next.drive_enable = (state_next == ST_READ) && emulating_next;
    result_next.data_bit     = (state_next == ST_READ) && emulating_next && last_bit_next;
    result_next.conflict     = mark;
    result_next.phase        = 2'(state_next);
    if (state_next == ST_LOAD) begin
      result_next.next_byte_address = '0;
    end else if ((state_next == ST_READ) && (bit_pos_next >= BIT_POS_W'(BYTE_BITS))) begin
      result_next.next_byte_address = NEXT_ADDR_W'(addr_inc);
    end else begin
      result_next.next_byte_address = NEXT_ADDR_W'(addr_next);
    end
  end

  // State and registered result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_LOAD;
      nib_count    <= '0;
      addr         <= '0;
      bit_pos      <= '0;
      last_bit     <= 1'b0;
      emulating    <= 1'b0;
      ignored      <= '0;
      result_valid <= 1'b0;
    end else begin
      if (fire) begin
        state      <= state_next;
        nib_count  <= nib_count_next;
        addr       <= addr_next;
        bit_pos    <= bit_pos_next;
        shift_byte <= shift_byte_next;
        last_bit   <= last_bit_next;
        emulating  <= emulating_next;
        ignored    <= ignored_next;
        result     <= result_next;
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  `SSRE_ASSERT(a_conflict_reported,
               (fire && mark) |=> result_valid && result.conflict,
               "line conflict was not reported")
  `SSRE_ASSERT(a_load_no_address,
               (result_valid && (result.phase == 2'(ST_LOAD))) |->
               (result.next_byte_address == '0) && !result.drive_enable,
               "loading phase shows an address or drives the line")
  `SSRE_ASSERT(a_marks_sticky,
               1'b1 |=> ($past(ignored) & ~ignored) == '0,
               "a slot ignore mark was cleared")

endmodule

// ===== hdl/serial_speech_rom_emulator.sv =====
// Top level of the serial speech ROM emulator: front classifier, command
// queue and back end. Depends on ssre_pkg, ssre_front, ssre_queue, ssre_back.
//
//   channel   direction   valid          stall          word
//   item      in          item_valid     item_stall     ssre_pkg::item_t
//   result    out         result_valid   result_stall   ssre_pkg::result_t
//
// One bus event word can be accepted every clock cycle while the queue is not
// full; it goes to a queue entry and its result word then to the back end's
// result register. The back end updates address, bit position and slot marks
// for one word per cycle while the result is not stalled. Reset clears all
// control state and every slot ignore mark at once. A stalled result holds
// the back end; the two-entry queue then fills and stalls the input channel.
`timescale 1ns / 1ps

module serial_speech_rom_emulator (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  ssre_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output ssre_pkg::result_t result
);
  import ssre_pkg::*;

  logic q_full;
  logic push;
  logic pop;
  logic q_valid;
  cmd_t push_cmd;
  cmd_t head;

  // Accept and classify incoming words.
  ssre_front u_front (
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .q_full     (q_full),
    .push       (push),
    .cmd        (push_cmd)
  );

  // Decouple the two sides.
  ssre_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .head     (head)
  );

  // Carry out the commands and register the results.
  ssre_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
